>>> sv/mtskl_pkg.sv
// Shared types and constants for the multi-table sorted key lookup block.
// No dependencies; used by mtskl_bank, the top level and the port checker.
package mtskl_pkg;

    // Default build parameters.
    localparam int DEF_TABLE_COUNT = 4;
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_KEY_BITS    = 32;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed interface geometry.
    localparam int OUT_TABLES  = 4;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int SEL_W       = 2;
    localparam int SLOT_W      = 8;
    localparam int FIELD_W     = 32;
    localparam int RESULT_W    = 1 + FIELD_W;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 136;

    // Input tdata layout, lowest bit first.
    localparam int SEL_LSB   = 0;
    localparam int SLOT_LSB  = SEL_LSB + SEL_W;
    localparam int KEY_LSB   = SLOT_LSB + SLOT_W;
    localparam int VALUE_LSB = KEY_LSB + FIELD_W;

    // Request kinds carried on tuser.
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // Top-level sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    // Per-table search status reported to the top level.
    typedef struct packed {
        logic               done;
        logic               found;
        logic [FIELD_W-1:0] value;
    } bank_status_t;

endpackage

>>> sv/multi_table_sorted_key_lookup.sv
// Write: the input stays ready for the next request, no result. Lookup: all tables are
// searched side by side, one probe per cycle per table from a registered memory read; a
// table of n entries takes up to floor(log2(n))+1 probes (9 for 256 entries), and the
// result is loaded into the output register once every table is done and that register
// is free. Asynchronous active-low reset clears the sequencer, the output valid flag and
// all entry counts; table contents are undefined until written.
// Depends on mtskl_pkg and mtskl_bank.
module multi_table_sorted_key_lookup #(
    parameter int TABLE_COUNT = mtskl_pkg::DEF_TABLE_COUNT,
    parameter int TABLE_DEPTH = mtskl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = mtskl_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = mtskl_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtskl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtskl_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // table_select[1:0], slot[9:2], key[41:10], entry_value[73:42], zero pad
    input  logic [mtskl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found_0, value_0, found_1, value_1, found_2, value_2, found_3, value_3, zero pad
    output logic [mtskl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NT = (TABLE_COUNT < mtskl_pkg::OUT_TABLES) ? TABLE_COUNT
                                                               : mtskl_pkg::OUT_TABLES;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    mtskl_pkg::state_t state_reg, state_next;

    logic                                 accept;
    logic                                 lookup_start;
    logic                                 write_req;
    logic                                 slot_ok;
    logic [mtskl_pkg::SEL_W-1:0]          in_sel;
    logic [mtskl_pkg::SLOT_W-1:0]         in_slot;
    logic [mtskl_pkg::FIELD_W-1:0]        in_key;
    logic [mtskl_pkg::FIELD_W-1:0]        in_value;
    logic [KEY_BITS-1:0]                  key_m;
    logic [VALUE_BITS-1:0]                value_m;

    logic [CW-1:0]                        count_reg [NT];
    mtskl_pkg::bank_status_t              stat [mtskl_pkg::OUT_TABLES];
    logic                                 all_done;
    logic                                 out_free;
    logic                                 load_out;
    logic                                 out_valid_reg, out_valid_next;
    logic [mtskl_pkg::OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    // Request decode.
    assign s_axis_tready = (state_reg == mtskl_pkg::ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_sel        = s_axis_tdata[mtskl_pkg::SEL_LSB +: mtskl_pkg::SEL_W];
    assign in_slot       = s_axis_tdata[mtskl_pkg::SLOT_LSB +: mtskl_pkg::SLOT_W];
    assign in_key        = s_axis_tdata[mtskl_pkg::KEY_LSB +: mtskl_pkg::FIELD_W];
    assign in_value      = s_axis_tdata[mtskl_pkg::VALUE_LSB +: mtskl_pkg::FIELD_W];
    assign key_m         = KEY_BITS'(in_key);
    assign value_m       = VALUE_BITS'(in_value);
    assign lookup_start  = accept && (s_axis_tuser == mtskl_pkg::OP_LOOKUP);
    assign write_req     = accept && (s_axis_tuser == mtskl_pkg::OP_WRITE);
    assign slot_ok       = (32'(in_slot) < 32'(TABLE_DEPTH));

    // Entry count registers, clamped to the table depth on write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NT; t++)
                count_reg[t] <= '0;
        end
        else if (cfg_we)
        begin
            for (int t = 0; t < NT; t++)
            begin
                if (cfg_index == mtskl_pkg::CFG_IDX_W'(t))
                begin
                    if (32'(cfg_data) > 32'(TABLE_DEPTH))
                        count_reg[t] <= CW'(TABLE_DEPTH);
                    else
                        count_reg[t] <= CW'(cfg_data);
                end
            end
        end
    end

    // One memory bank and search engine per table; absent tables report not found.
    for (genvar t = 0; t < mtskl_pkg::OUT_TABLES; t++)
    begin : g_table
        if (t < NT)
        begin : g_bank
            mtskl_bank #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .KEY_BITS    (KEY_BITS),
                .VALUE_BITS  (VALUE_BITS)
            ) u_bank (
                .clk         (clk),
                .rst_n       (rst_n),
                .wr_en       (write_req && slot_ok && (in_sel == mtskl_pkg::SEL_W'(t))),
                .wr_slot     (AW'(in_slot)),
                .wr_key      (key_m),
                .wr_value    (value_m),
                .start       (lookup_start),
                .search_key  (key_m),
                .entry_count (count_reg[t]),
                .status      (stat[t])
            );
        end
        else
        begin : g_absent
            assign stat[t].done  = 1'b1;
            assign stat[t].found = 1'b0;
            assign stat[t].value = '0;
        end
    end

    // Gather the per-table results into one output word.
    always_comb
    begin
        all_done      = 1'b1;
        out_data_next = '0;
        for (int t = 0; t < mtskl_pkg::OUT_TABLES; t++)
        begin
            all_done = all_done && stat[t].done;
            out_data_next[t*mtskl_pkg::RESULT_W]                  = stat[t].found;
            out_data_next[t*mtskl_pkg::RESULT_W + 1 +: mtskl_pkg::FIELD_W] = stat[t].value;
        end
    end

    // Sequencer and output register handoff.
    assign out_free = !out_valid_reg || m_axis_tready;
    assign load_out = (state_reg == mtskl_pkg::ST_SEARCH) && all_done && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtskl_pkg::ST_IDLE:
            begin
                if (lookup_start)
                    state_next = mtskl_pkg::ST_SEARCH;
            end
            mtskl_pkg::ST_SEARCH:
            begin
                if (load_out)
                    state_next = mtskl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mtskl_pkg::ST_IDLE;
            end
        endcase
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtskl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> sv/mtskl_bank.sv
// One table: key and value memories plus the binary search engine over them.
// Depends on mtskl_pkg.
module mtskl_bank #(
    parameter int TABLE_DEPTH = mtskl_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = mtskl_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS  = mtskl_pkg::DEF_VALUE_BITS,
    localparam int AW         = $clog2(TABLE_DEPTH),
    localparam int CW         = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_slot,
    input  logic [KEY_BITS-1:0]        wr_key,
    input  logic [VALUE_BITS-1:0]      wr_value,
    input  logic                       start,
    input  logic [KEY_BITS-1:0]        search_key,
    input  logic [CW-1:0]              entry_count,
    output mtskl_pkg::bank_status_t    status
);

    // Table storage, one synchronous read port and one write port.
    logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]   rkey_reg;
    logic [VALUE_BITS-1:0] rval_reg;
    logic [AW-1:0]         rd_addr;

    // Search state.
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          found_reg, found_next;
    logic [mtskl_pkg::FIELD_W-1:0] value_reg, value_next;
    logic [CW-1:0]                 base_reg, base_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [KEY_BITS-1:0]           skey_reg, skey_next;

    logic [CW-1:0] half;
    logic [CW-1:0] step_base;
    logic [CW-1:0] step_count;
    logic          key_eq;
    logic          key_gt;

    // Narrow the search window from the entry that was just read.
    always_comb
    begin
        half   = count_reg >> 1;
        key_eq = (skey_reg == rkey_reg);
        key_gt = (skey_reg > rkey_reg);
        if (key_gt)
        begin
            step_base  = base_reg + half + CW'(1);
            step_count = (count_reg - CW'(1)) >> 1;
        end
        else
        begin
            step_base  = base_reg;
            step_count = half;
        end
        if (start)
            rd_addr = AW'(entry_count >> 1);
        else
            rd_addr = AW'(step_base + (step_count >> 1));
    end

    // Next-state logic of the probe loop.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        found_next = found_reg;
        value_next = value_reg;
        base_next  = base_reg;
        count_next = count_reg;
        skey_next  = skey_reg;
        if (start)
        begin
            skey_next  = search_key;
            base_next  = '0;
            count_next = entry_count;
            busy_next  = (entry_count != '0);
            done_next  = (entry_count == '0);
            found_next = 1'b0;
            value_next = '0;
        end
        else if (busy_reg)
        begin
            if (key_eq)
            begin
                found_next = 1'b1;
                value_next = mtskl_pkg::FIELD_W'(rval_reg);
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            else if (step_count == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                base_next  = step_base;
                count_next = step_count;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b1;
            found_reg <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            value_reg <= value_next;
        end
    end

    // Search window and key; no reset needed.
    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        count_reg <= count_next;
        skey_reg  <= skey_next;
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_slot] <= wr_key;
            val_mem[wr_slot] <= wr_value;
        end
        rkey_reg <= key_mem[rd_addr];
        rval_reg <= val_mem[rd_addr];
    end

    assign status.done  = done_reg;
    assign status.found = found_reg;
    assign status.value = value_reg;

endmodule

>>> sv/mtskl_checker.sv
// Port-level checks of the multi-table sorted key lookup, bound to the top level.
// Depends on mtskl_pkg and multi_table_sorted_key_lookup.
module mtskl_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [mtskl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result payload changed while stalled");

    // A lookup request closes the input until its search ends.
    a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mtskl_pkg::OP_LOOKUP)
        |=> !s_axis_tready)
        else $error("input open during a search");

    // A write request leaves the input open for the next request.
    a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mtskl_pkg::OP_WRITE)
        |=> s_axis_tready)
        else $error("input closed after a write");

    // A new result appears only as a search finishes.
    a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
        else $error("result without a finished search");

endmodule

bind multi_table_sorted_key_lookup mtskl_checker u_mtskl_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for multi_table_sorted_key_lookup: drives write and lookup
// requests, predicts each lookup result from a shadow copy of the tables and compares it.
// Depends on mtskl_pkg and the RTL of the block; needs no other file.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLES        = mtskl_pkg::OUT_TABLES;
    localparam int DEPTH         = mtskl_pkg::DEF_TABLE_DEPTH;
    localparam int FIELD_W       = mtskl_pkg::FIELD_W;
    localparam int RESULT_W      = mtskl_pkg::RESULT_W;
    localparam int CFG_W         = mtskl_pkg::CFG_W;
    localparam int CFG_IDX_W     = mtskl_pkg::CFG_IDX_W;
    localparam int SEL_W         = mtskl_pkg::SEL_W;
    localparam int SLOT_W        = mtskl_pkg::SLOT_W;
    localparam int IN_TDATA_W    = mtskl_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W   = mtskl_pkg::OUT_TDATA_W;
    localparam int SEL_LSB       = mtskl_pkg::SEL_LSB;
    localparam int SLOT_LSB      = mtskl_pkg::SLOT_LSB;
    localparam int KEY_LSB       = mtskl_pkg::KEY_LSB;
    localparam int VALUE_LSB     = mtskl_pkg::VALUE_LSB;
    localparam int REQUEST_GOAL  = 1150;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PERCENT  = 36;

    // Expected per-table outcome of one lookup.
    typedef struct packed {
        logic [TABLES-1:0]              found;
        logic [TABLES-1:0][FIELD_W-1:0] value;
    } lookup_result_t;

    // Ways of filling a table with keys.
    typedef enum int {
        FILL_DENSE,
        FILL_WIDE,
        FILL_UNSORTED,
        FILL_LADDER
    } fill_mode_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // table_select, slot, key, entry_value, zero pad
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    // op
    logic                    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // found_0, value_0, found_1, value_1, found_2, value_2, found_3, value_3, zero pad
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // Shadow copy of the tables and entry counts.
    logic [FIELD_W-1:0] key_mem [TABLES][DEPTH];
    logic [FIELD_W-1:0] val_mem [TABLES][DEPTH];
    bit                 slot_written [TABLES][DEPTH];
    int unsigned        written_prefix [TABLES];
    int unsigned        entry_count [TABLES];

    lookup_result_t     pending_lookups[$];
    int                 mismatch_count;
    int                 requests_sent;
    int unsigned        cycle_count;
    bit                 no_idle;

    multi_table_sorted_key_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_table_sorted_key_lookup verification failed");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Binary search of every table in the shadow copy, probe for probe.
    function automatic lookup_result_t search_all_tables(input logic [FIELD_W-1:0] k);
        lookup_result_t res;
        int unsigned    span;
        int unsigned    base;
        int unsigned    pos;
        res = '0;
        for (int t = 0; t < TABLES; t++)
        begin
            span = (entry_count[t] > DEPTH) ? DEPTH : entry_count[t];
            base = 0;
            while (span > 0)
            begin
                pos = base + span / 2;
                if (pos >= DEPTH)
                    break;
                if (k == key_mem[t][pos])
                begin
                    res.found[t] = 1'b1;
                    res.value[t] = val_mem[t][pos];
                    break;
                end
                if (k > key_mem[t][pos])
                begin
                    base = base + span / 2 + 1;
                    span = span - 1;
                end
                span = span / 2;
            end
        end
        return res;
    endfunction

    // Compare each accepted result with the oldest pending lookup.
    always @(posedge clk)
    begin : check_results
        lookup_result_t exp_res;
        logic           got_found;
        logic [FIELD_W-1:0] got_value;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("result arrived with no lookup pending");
            else
            begin
                exp_res = pending_lookups.pop_front();
                for (int t = 0; t < TABLES; t++)
                begin
                    got_found = m_axis_tdata[t * RESULT_W];
                    got_value = m_axis_tdata[t * RESULT_W + 1 +: FIELD_W];
                    if (got_found !== exp_res.found[t])
                        report_mismatch($sformatf("found_%0d got %b expected %b",
                                                  t, got_found, exp_res.found[t]));
                    if (got_value !== exp_res.value[t])
                        report_mismatch($sformatf("value_%0d got %h expected %h",
                                                  t, got_value, exp_res.value[t]));
                end
            end
        end
    end

    // Send one request, with random idle cycles before it unless no_idle is set, and predict its effect.
    task automatic send_request(input mtskl_pkg::op_t op, input logic [SEL_W-1:0] sel,
                                input logic [SLOT_W-1:0] slot, input logic [FIELD_W-1:0] k,
                                input logic [FIELD_W-1:0] v);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[SEL_LSB +: SEL_W]     = sel;
        word[SLOT_LSB +: SLOT_W]   = slot;
        word[KEY_LSB +: FIELD_W]   = k;
        word[VALUE_LSB +: FIELD_W] = v;
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        if (op == mtskl_pkg::OP_WRITE)
        begin
            key_mem[sel][slot] = k;
            val_mem[sel][slot] = v;
            slot_written[sel][slot] = 1'b1;
            while (written_prefix[sel] < DEPTH && slot_written[sel][written_prefix[sel]])
                written_prefix[sel]++;
        end
        else
            pending_lookups.push_back(search_all_tables(k));
    endtask

    task automatic write_entry(input int t, input int slot, input logic [FIELD_W-1:0] k,
                               input logic [FIELD_W-1:0] v);
        send_request(mtskl_pkg::OP_WRITE, SEL_W'(t), SLOT_W'(slot), k, v);
    endtask

    // Lookup fields that the block ignores carry random bits.
    task automatic lookup_key(input logic [FIELD_W-1:0] k);
        send_request(mtskl_pkg::OP_LOOKUP, SEL_W'($urandom), SLOT_W'($urandom), k, $urandom);
    endtask

    // Stop sending and wait until every lookup has returned and the block has settled.
    task automatic wait_for_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input int t, input int unsigned n);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(t);
        cfg_data  <= CFG_W'(n);
        @(negedge clk);
        cfg_we    <= 1'b0;
        entry_count[t] = n & ((1 << CFG_W) - 1);
    endtask

    // Write slots 0..n-1 of one table with keys of the given shape.
    task automatic load_table(input int t, input int n, input fill_mode_t mode);
        logic [FIELD_W-1:0] keys[$];
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                FILL_DENSE:  keys.push_back($urandom_range(0, 3 * n));
                FILL_LADDER: keys.push_back({8'(i), 24'($urandom)});
                default:     keys.push_back($urandom);
            endcase
        end
        if (mode == FILL_DENSE || mode == FILL_WIDE)
            keys.sort();
        for (int i = 0; i < n; i++)
            write_entry(t, i, keys[i], $urandom);
    endtask

    // A key that mostly hits one of the configured tables.
    function automatic logic [FIELD_W-1:0] pick_key();
        int          t;
        int unsigned r;
        logic [FIELD_W-1:0] k;
        t = $urandom_range(0, TABLES - 1);
        r = $urandom_range(99);
        if (entry_count[t] == 0 || r >= 85)
            return $urandom;
        k = key_mem[t][$urandom_range(0, ((entry_count[t] > DEPTH) ? DEPTH : entry_count[t]) - 1)];
        if (r < 55)
            return k;
        if (r < 75)
            return r[0] ? k + 1 : k - 1;
        return r[0] ? '1 : '0;
    endfunction

    // Right after reset every table is empty.
    task automatic test_empty_tables();
        lookup_key('0);
        lookup_key('1);
        wait_for_idle();
    endtask

    // Small hand-built tables: single entry, two entries, duplicates and an unsorted one.
    task automatic test_small_tables();
        write_entry(0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
        write_entry(1, 0, 32'h0000_0005, 32'h0000_0000);
        write_entry(1, 1, 32'hFFFF_FFFF, 32'hAAAA_5555);
        write_entry(2, 0, 32'h0000_0007, 32'h0000_0001);
        write_entry(2, 1, 32'h0000_0007, 32'h0000_0002);
        write_entry(2, 2, 32'h0000_0007, 32'h0000_0003);
        write_entry(3, 0, 32'h0000_0009, 32'h5555_AAAA);
        write_entry(3, 1, 32'h0000_0003, 32'h1234_5678);
        write_entry(3, 2, 32'h0000_000C, 32'h8765_4321);
        write_entry(3, 3, 32'h0000_0001, 32'hDEAD_0001);
        write_entry(3, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_for_idle();
        set_entry_count(0, 1);
        set_entry_count(1, 2);
        set_entry_count(2, 3);
        set_entry_count(3, 4);
        lookup_key(32'h0000_0000);
        lookup_key(32'h0000_0005);
        lookup_key(32'h0000_0007);
        lookup_key(32'hFFFF_FFFF);
        lookup_key(32'h0000_0003);
        lookup_key(32'h0000_000C);
        lookup_key(32'h0000_0001);
        lookup_key(32'h0000_0009);
        lookup_key(32'h0000_0006);
        wait_for_idle();
    endtask

    // One table filled to full depth, then an entry count beyond the depth.
    task automatic test_full_table();
        int t;
        t = $urandom_range(0, TABLES - 1);
        load_table(t, DEPTH, FILL_LADDER);
        wait_for_idle();
        for (int i = 0; i < TABLES; i++)
            set_entry_count(i, (i == t) ? DEPTH : 0);
        lookup_key(key_mem[t][0]);
        lookup_key(key_mem[t][DEPTH - 1]);
        lookup_key(key_mem[t][DEPTH / 2]);
        for (int i = 0; i < 8; i++)
            lookup_key(pick_key());
        wait_for_idle();
        set_entry_count(t, (1 << CFG_W) - 1);
        lookup_key(key_mem[t][DEPTH - 1]);
        for (int i = 0; i < 5; i++)
            lookup_key(pick_key());
        wait_for_idle();
    endtask

    // Random phases: reload some tables, reconfigure, then mostly lookups with stray writes.
    task automatic test_random_phases();
        int phase;
        int n;
        int lookups;
        int t;
        fill_mode_t mode;
        phase = 0;
        while (requests_sent < REQUEST_GOAL)
        begin
            no_idle = (phase == 3 || phase == 4);
            for (int i = 0; i < TABLES; i++)
            begin
                if ($urandom_range(1) == 1)
                begin
                    n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                    case ($urandom_range(7))
                        0:       mode = FILL_UNSORTED;
                        1, 2, 3: mode = FILL_DENSE;
                        default: mode = FILL_WIDE;
                    endcase
                    load_table(i, n, mode);
                end
                if ($urandom_range(4) == 0)
                    write_entry(i, $urandom_range(0, DEPTH - 1), $urandom, $urandom);
            end
            wait_for_idle();
            for (int i = 0; i < TABLES; i++)
            begin
                if ($urandom_range(5) == 0)
                    set_entry_count(i, 0);
                else
                    set_entry_count(i, $urandom_range(0, written_prefix[i]));
            end
            lookups = $urandom_range(8, 30);
            for (int i = 0; i < lookups; i++)
            begin
                if (phase == 6 && i == lookups / 2)
                    wait_for_idle();
                if ($urandom_range(9) == 0)
                begin
                    t = $urandom_range(0, TABLES - 1);
                    write_entry(t, $urandom_range(0, (written_prefix[t] < DEPTH) ?
                                written_prefix[t] : DEPTH - 1), pick_key(), $urandom);
                end
                else
                    lookup_key(pick_key());
            end
            wait_for_idle();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        for (int t = 0; t < TABLES; t++)
        begin
            written_prefix[t] = 0;
            entry_count[t]    = 0;
            for (int s = 0; s < DEPTH; s++)
            begin
                key_mem[t][s]      = '0;
                val_mem[t][s]      = '0;
                slot_written[t][s] = 1'b0;
            end
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_tables();
        test_small_tables();
        test_full_table();
        test_random_phases();
        wait_for_idle();

        if (mismatch_count == 0)
            $display("multi_table_sorted_key_lookup verification clean");
        else
            $display("multi_table_sorted_key_lookup verification failed");
        $finish;
    end

endmodule
